// File: hdl/aes128_ctr_decryptor_macros.svh
// assertion macros shared by the checker of the counter-mode decryptor
// depends on nothing; the user supplies clk and rst in scope
`ifndef AES128_CTR_DECRYPTOR_MACROS_SVH
`define AES128_CTR_DECRYPTOR_MACROS_SVH

// property checked outside reset
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also spans the reset itself
`define CHK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/aesctr_pkg.sv
// shared types, constants and aes round functions for the ctr decryptor
// depends on nothing
package aesctr_pkg;

  localparam int BLK_W   = 128;
  localparam int HALF_W  = 64;
  localparam int SBLK_W  = 28;
  localparam int IN_W    = 160;
  localparam int IDX_W   = 2;
  localparam logic [3:0] LAST_ROUND = 4'd10;

  // register indexes
  localparam logic [IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_IV_LOW   = 2'd3;

  // one queued block: counter value and ciphertext
  typedef struct packed {
    logic [BLK_W-1:0] ctr;
    logic [BLK_W-1:0] data;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits in bits 127-8i down, byte r of column c is i = r + 4c
  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                 input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BLK_W-1:0] res;
    for (int i = 0; i < 16; i++) b[i] = s[BLK_W-1-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r+4*c] = SBOX[b[r+4*((c+r)%4)]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) res[BLK_W-1-8*i -: 8] = t[i];
    aes_round = res;
  endfunction

  // next round key from the current one
  function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] rk,
                                                input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = rk[127:96]; w1 = rk[95:64]; w2 = rk[63:32]; w3 = rk[31:0];
    t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    key_step = {n0, n1, n2, n3};
  endfunction

endpackage

// File: hdl/aesctr_front.sv
// front end: takes blocks, keeps the 128-bit counter, handles restarts
// depends on aesctr_pkg
module aesctr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                restart,
  input  logic [aesctr_pkg::SBLK_W-1:0]       start_block,
  input  logic [aesctr_pkg::BLK_W-1:0]        data,
  input  logic [aesctr_pkg::BLK_W-1:0]        iv,
  input  logic                                q_ready,
  output logic                                q_push,
  output aesctr_pkg::job_t                    q_job
);
  import aesctr_pkg::*;

  logic [BLK_W-1:0] counter;
  logic [BLK_W-1:0] counter_next;
  logic [BLK_W-1:0] ctr_use;
  logic [BLK_W-1:0] sb_ext;

  // restart sum and its successor come from one adder each
  always_comb begin
    sb_ext = {{(BLK_W-SBLK_W){1'b0}}, start_block};
    ctr_use = restart ? iv + sb_ext : counter;
    counter_next = restart ? iv + sb_ext + {{(BLK_W-1){1'b0}}, 1'b1}
                           : counter + {{(BLK_W-1){1'b0}}, 1'b1};
  end

  assign q_push   = in_valid && q_ready;
  assign q_job.ctr  = ctr_use;
  assign q_job.data = data;

  // counter advances once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (q_push) begin
      counter <= counter_next;
    end
  end

endmodule

// File: hdl/aesctr_fifo.sv
// two-entry queue between the front end and the cipher core
// depends on aesctr_pkg
module aesctr_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  aesctr_pkg::job_t  push_job,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output aesctr_pkg::job_t  pop_job
);
  import aesctr_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready   = (count != 2'd2);
  assign valid   = (count != 2'd0);
  assign pop_job = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/aesctr_core.sv
// back end: iterative aes-128, one round a cycle, key expanded on the fly
// depends on aesctr_pkg
module aesctr_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [aesctr_pkg::BLK_W-1:0]  key,
  input  logic                          job_valid,
  input  aesctr_pkg::job_t              job,
  output logic                          job_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aesctr_pkg::BLK_W-1:0]  out_data
);
  import aesctr_pkg::*;

  logic             busy;
  logic [3:0]       round;
  logic [7:0]       rcon;
  logic [BLK_W-1:0] state;
  logic [BLK_W-1:0] rk;
  logic [BLK_W-1:0] data;
  logic [BLK_W-1:0] rk_next;
  logic [BLK_W-1:0] state_next;
  logic             last;
  logic             finish;

  // one round of cipher and key schedule
  always_comb begin
    last       = (round == LAST_ROUND);
    rk_next    = key_step(rk, rcon);
    state_next = aes_round(state, last) ^ rk_next;
    finish     = busy && last && (!out_valid || out_ready);
  end

  assign job_pop = !busy && job_valid;

  // round sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= 4'd0;
    end else if (job_pop) begin
      busy  <= 1'b1;
      round <= 4'd1;
    end else if (busy && !last) begin
      round <= round + 4'd1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      state <= job.ctr ^ key;
      rk    <= key;
      rcon  <= 8'h01;
      data  <= job.data;
    end else if (busy && !last) begin
      state <= state_next;
      rk    <= rk_next;
      rcon  <= xtime(rcon);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= data ^ state_next;
    end
  end

endmodule

// File: hdl/aes128_ctr_decryptor.sv
// top level of the aes-128 counter-mode decryptor
// depends on aesctr_pkg, aesctr_front, aesctr_fifo, aesctr_core
//
// channel   dir  handshake          content
// s_*       in   tvalid/tready      ciphertext block, restart flag
// m_*       out  tvalid/tready      plaintext block
// cfg_*     in   cfg_we             key and initial counter, 128 bits each, written in 64-bit halves
//
// each block passes through the round unit as one load with key add,
// then ten rounds; it starts a new block only after finishing the last one, so this unit sets the sustained rate.
// a two-entry queue lets the input take blocks while the core works and
// while a finished block waits in the output register.
// reset is synchronous and clears the control state, the configuration registers and the counter.
module aes128_ctr_decryptor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // start_block[27:0], data_high[91:28], data_low[155:92], zero pad
  input  logic [aesctr_pkg::IN_W-1:0]       s_tdata,
  // restart
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // plain_high[63:0], plain_low[127:64]
  output logic [aesctr_pkg::BLK_W-1:0]      m_tdata,
  input  logic                              cfg_we,
  input  logic [aesctr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [aesctr_pkg::HALF_W-1:0]     cfg_data
);
  import aesctr_pkg::*;

  logic [HALF_W-1:0] key_high, key_low, iv_high, iv_low;
  logic              q_ready, q_push, q_valid, q_pop;
  job_t              q_in, q_out;
  logic [BLK_W-1:0]  in_block;
  logic [BLK_W-1:0]  out_block;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      iv_high  <= '0;
      iv_low   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_IV_HIGH:  iv_high  <= cfg_data;
        REG_IV_LOW:   iv_low   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // unpack the block: first bytes on the high side of the counter order
  assign in_block = {s_tdata[91:28], s_tdata[155:92]};
  assign s_tready = q_ready;

  aesctr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .restart     (s_tuser),
    .start_block (s_tdata[SBLK_W-1:0]),
    .data        (in_block),
    .iv          ({iv_high, iv_low}),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_job       (q_in)
  );

  aesctr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_out)
  );

  aesctr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .key       ({key_high, key_low}),
    .job_valid (q_valid),
    .job       (q_out),
    .job_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_block)
  );

  assign m_tdata = {out_block[HALF_W-1:0], out_block[BLK_W-1:HALF_W]};

endmodule

// File: hdl/aesctr_checker.sv
// port-level checker for the counter-mode decryptor, bound to the top level
// depends on aes128_ctr_decryptor_macros.svh
`include "aes128_ctr_decryptor_macros.svh"

module aesctr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // a stalled result holds its data
  `CHK_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // an offered input transaction stays offered until taken
  `CHK_ASSERT(a_in_hold, s_tvalid && !s_tready |=> s_tvalid, "input withdrawn while stalled")

  // no result straight out of reset
  `CHK_ASSERT_RST(a_rst_out, rst |=> !m_tvalid, "result valid after reset")

  // queue is empty after reset, so input is ready
  `CHK_ASSERT_RST(a_rst_in, rst |=> s_tready, "input not ready after reset")

endmodule

bind aes128_ctr_decryptor aesctr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/sv/aes128_ctr_decryptor_tb.sv
// self-checking testbench of the aes-128 counter-mode decryptor
// depends on aesctr_pkg and aes128_ctr_decryptor; predicts every plaintext block
module aes128_ctr_decryptor_tb;
  import aesctr_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  // start_block[27:0], data_high[91:28], data_low[155:92], zero pad
  logic [IN_W-1:0]     s_tdata;
  // restart
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  // plain_high[63:0], plain_low[127:64]
  logic [BLK_W-1:0]    m_tdata;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [HALF_W-1:0]   cfg_data;

  typedef struct packed {
    logic [HALF_W-1:0] plain_high;
    logic [HALF_W-1:0] plain_low;
  } plain_t;

  // shadow state of the block
  logic [BLK_W-1:0] shadow_key;
  logic [BLK_W-1:0] shadow_iv;
  logic [BLK_W-1:0] shadow_ctr;

  plain_t plain_q[$];
  int     mismatches;
  int     blocks_sent;
  int     blocks_checked;
  int     restarts_sent;
  int     burst_left;
  int     hold_left;
  int     ready_mode_left;
  bit     ready_always;
  int     idle_cycles;

  aes128_ctr_decryptor DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // fips-197 encryption, byte i of a block in bits 127-8i down
  function automatic logic [BLK_W-1:0] aes_encrypt_block(input logic [BLK_W-1:0] key,
                                                         input logic [BLK_W-1:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] tw [4];
    logic [7:0] rcon, x, a0, a1, a2, a3, al;
    logic [BLK_W-1:0] res;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[BLK_W-1-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tw[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        x = tw[0];
        tw[0] = SBOX[tw[1]] ^ rcon;
        tw[1] = SBOX[tw[2]];
        tw[2] = SBOX[tw[3]];
        tw[3] = SBOX[x];
        rcon = gf_double(rcon);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ tw[j];
    end
    for (int i = 0; i < 16; i++) st[i] = blk[BLK_W-1-8*i -: 8] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // sub bytes and shift rows
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          tmp[r+4*c] = SBOX[st[r+4*((c+r)%4)]];
      // mix columns except in the last round
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
          tmp[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
          tmp[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
          tmp[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) res[BLK_W-1-8*i -: 8] = st[i];
    return res;
  endfunction

  // expected plaintext of one accepted block, advances the shadow counter
  task automatic predict_plain(input bit restart, input logic [SBLK_W-1:0] sblk,
                               input logic [HALF_W-1:0] dh, input logic [HALF_W-1:0] dl);
    logic [BLK_W-1:0] stream;
    plain_t p;
    if (restart) shadow_ctr = shadow_iv + {{(BLK_W-SBLK_W){1'b0}}, sblk};
    stream = aes_encrypt_block(shadow_key, shadow_ctr);
    p.plain_high = dh ^ stream[127:64];
    p.plain_low  = dl ^ stream[63:0];
    plain_q.push_back(p);
    shadow_ctr = shadow_ctr + {{(BLK_W-1){1'b0}}, 1'b1};
  endtask

  task automatic report_mismatch(input string what, input logic [HALF_W-1:0] got,
                                 input logic [HALF_W-1:0] want);
    $display("mismatch on block %0d: %s got %h expected %h", blocks_checked, what, got, want);
    mismatches++;
  endtask

  // all tasks below start and end at a falling edge
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_HIGH: shadow_key[127:64] = val;
      REG_KEY_LOW:  shadow_key[63:0]   = val;
      REG_IV_HIGH:  shadow_iv[127:64]  = val;
      REG_IV_LOW:   shadow_iv[63:0]    = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_key_iv(input logic [BLK_W-1:0] key, input logic [BLK_W-1:0] iv);
    write_reg(REG_KEY_HIGH, key[127:64]);
    write_reg(REG_KEY_LOW, key[63:0]);
    write_reg(REG_IV_HIGH, iv[127:64]);
    write_reg(REG_IV_LOW, iv[63:0]);
  endtask

  // offer one block, with idle gaps between bursts of transactions
  task automatic send_block(input bit restart, input logic [SBLK_W-1:0] sblk,
                            input logic [HALF_W-1:0] dh, input logic [HALF_W-1:0] dl);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tuser <= restart;
    s_tdata <= {4'b0, dl, dh, sblk};
    do @(posedge clk); while (!s_tready);
    predict_plain(restart, sblk, dh, dl);
    blocks_sent++;
    if (restart) restarts_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_random(input bit restart);
    send_block(restart, SBLK_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // wait until every plaintext block is back and the core is quiet
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (plain_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_counter_from_reset;
    // no restart yet: counter starts at zero under the zero key
    send_block(1'b0, '0, '0, '0);
    send_block(1'b0, '1, '1, '1);
    send_block(1'b0, '0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
  endtask

  task automatic test_directed_extremes;
    load_key_iv(128'h2b7e151628aed2a6abf7158809cf4f3c,
                128'hf0f1f2f3f4f5f6f7f8f9fafbfcfdfeff);
    send_block(1'b1, '0, '0, '0);
    send_block(1'b0, '0, '1, '1);
    send_block(1'b0, '1, '0, '1);
    send_block(1'b1, '1, '1, '0);
    send_block(1'b1, 28'h5555555, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();
    // new iv is not used until the next restart
    write_reg(REG_IV_LOW, 64'h1234);
    send_random(1'b0);
    send_random(1'b1);
    drain();
    // restart sum carries into the upper half and past 2^128
    load_key_iv('1, '1);
    send_block(1'b1, '1, '0, '0);
    send_block(1'b1, 28'd1, '1, '1);
    drain();
    // counter at all ones wraps to zero on increment
    load_key_iv('0, '1);
    send_block(1'b1, '0, '0, '0);
    send_block(1'b0, '0, '0, '0);
    send_block(1'b0, '0, '0, '0);
    drain();
    // lower half wraps into the upper half
    write_reg(REG_IV_HIGH, 64'h7);
    write_reg(REG_IV_LOW, 64'hfffffffffffffffe);
    send_block(1'b1, '0, '1, '0);
    send_block(1'b0, '0, '1, '0);
    send_block(1'b0, '0, '1, '0);
    drain();
  endtask

  // runs of blocks, mostly opened by a restart, under several key and iv settings
  task automatic test_random_streams;
    logic [BLK_W-1:0] key, iv;
    int run_len;
    for (int ph = 0; ph < 4; ph++) begin
      key = {$urandom, $urandom, $urandom, $urandom};
      case (ph)
        0: iv = '0;
        1: iv = '1;
        2: iv = {64'h0, 64'hfffffffff0000000};
        default: iv = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_key_iv(key, iv);
      for (int n = 0; n < 390; ) begin
        run_len = $urandom_range(1, 24);
        // mostly proper runs, now and then a run with no restart
        send_random($urandom_range(0, 9) != 0);
        for (int k = 1; k < run_len; k++) send_random($urandom_range(0, 19) == 0);
        n += run_len;
      end
      drain();
    end
  endtask

  // hold the output off so the queue fills and the input stalls
  task automatic test_output_backpressure;
    load_key_iv({$urandom, $urandom, $urandom, $urandom},
                {$urandom, $urandom, $urandom, $urandom});
    hold_left = 400;
    send_random(1'b1);
    for (int k = 0; k < 30; k++) send_random(1'b0);
    drain();
  endtask

  // output ready: long stalls on demand, otherwise alternating modes
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_mode_left = 0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      if (ready_mode_left == 0) begin
        ready_always = $urandom_range(0, 2) == 0;
        ready_mode_left = $urandom_range(30, 200);
      end
      ready_mode_left--;
      m_tready <= ready_always || ($urandom_range(0, 9) < 6);
    end
  end

  // result checking
  always @(posedge clk) begin
    plain_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (plain_q.size() == 0) begin
        report_mismatch("unexpected block", m_tdata[63:0], '0);
      end else begin
        want = plain_q.pop_front();
        if (m_tdata[63:0] !== want.plain_high)
          report_mismatch("plain_high", m_tdata[63:0], want.plain_high);
        if (m_tdata[127:64] !== want.plain_low)
          report_mismatch("plain_low", m_tdata[127:64], want.plain_low);
      end
      blocks_checked++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d blocks outstanding", plain_q.size());
      $display("aes128_ctr_decryptor test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_tready = 1'b0;
    shadow_key = '0;
    shadow_iv = '0;
    shadow_ctr = '0;
    mismatches = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    restarts_sent = 0;
    burst_left = 0;
    hold_left = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_counter_from_reset();
    test_directed_extremes();
    test_random_streams();
    test_output_backpressure();

    $display("covered %0d blocks (%0d restarts) over several keys and ivs,", blocks_sent,
             restarts_sent);
    $display("counter wraps, idle input gaps and a long output stall; %0d checked",
             blocks_checked);
    if (mismatches == 0) begin
      $display("aes128_ctr_decryptor test passed");
    end else begin
      $display("aes128_ctr_decryptor test failed");
    end
    $finish;
  end

endmodule

// File: aes128_ctr_decryptor.f
+incdir+hdl
hdl/aesctr_pkg.sv
hdl/aesctr_front.sv
hdl/aesctr_fifo.sv
hdl/aesctr_core.sv
hdl/aes128_ctr_decryptor.sv
hdl/aesctr_checker.sv
tb/sv/aes128_ctr_decryptor_tb.sv
